@@ hw/rtl/kevd_pkg.sv @@
// Shared constants, types and translation tables for the PS/2 key event decoder.
`timescale 1ns / 1ps
`default_nettype none

package kevd_pkg;

  // Depth of the key event ring; one slot always stays empty.
  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CODE_W      = 7;
  localparam int EVENT_W     = CODE_W + 1;

  // Set 2 bytes with a special meaning.
  localparam logic [7:0] BYTE_BREAK    = 8'hF0;
  localparam logic [7:0] BYTE_EXTEND   = 8'hE0;
  localparam logic [7:0] BYTE_PAUSE    = 8'hE1;
  localparam logic [7:0] BYTE_ACK      = 8'hFA;
  localparam logic [7:0] BYTE_SELFTEST = 8'hAA;

  // Command codes of the input channel.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // One operation handed from the front to the back.
  typedef struct packed {
    logic              is_pop;
    logic              pressed;
    logic [CODE_W-1:0] code;
  } op_t;

  // Translation of a plain Set 2 byte; zero means no key.
  function automatic logic [CODE_W-1:0] normal_rom(input logic [7:0] b);
    logic [CODE_W-1:0] c;
    case (b)
      8'h01: c = 7'h43;  8'h03: c = 7'h3f;  8'h04: c = 7'h3d;  8'h05: c = 7'h3b;
      8'h06: c = 7'h3c;  8'h07: c = 7'h58;  8'h09: c = 7'h44;  8'h0A: c = 7'h42;
      8'h0B: c = 7'h40;  8'h0C: c = 7'h3e;  8'h0D: c = 7'h0f;  8'h0E: c = 7'h29;
      8'h11: c = 7'h38;  8'h12: c = 7'h2a;  8'h14: c = 7'h1d;  8'h15: c = 7'h10;
      8'h16: c = 7'h02;  8'h1A: c = 7'h2c;  8'h1B: c = 7'h1f;  8'h1C: c = 7'h1e;
      8'h1D: c = 7'h11;  8'h1E: c = 7'h03;  8'h21: c = 7'h2e;  8'h22: c = 7'h2d;
      8'h23: c = 7'h20;  8'h24: c = 7'h12;  8'h25: c = 7'h05;  8'h26: c = 7'h04;
      8'h29: c = 7'h39;  8'h2A: c = 7'h2f;  8'h2B: c = 7'h21;  8'h2C: c = 7'h14;
      8'h2D: c = 7'h13;  8'h2E: c = 7'h06;  8'h31: c = 7'h31;  8'h32: c = 7'h30;
      8'h33: c = 7'h23;  8'h34: c = 7'h22;  8'h35: c = 7'h15;  8'h36: c = 7'h07;
      8'h3A: c = 7'h32;  8'h3B: c = 7'h24;  8'h3C: c = 7'h16;  8'h3D: c = 7'h08;
      8'h3E: c = 7'h09;  8'h41: c = 7'h33;  8'h42: c = 7'h25;  8'h43: c = 7'h17;
      8'h44: c = 7'h18;  8'h45: c = 7'h0b;  8'h46: c = 7'h0a;  8'h49: c = 7'h34;
      8'h4A: c = 7'h35;  8'h4B: c = 7'h26;  8'h4C: c = 7'h27;  8'h4D: c = 7'h19;
      8'h4E: c = 7'h0c;  8'h52: c = 7'h28;  8'h54: c = 7'h1a;  8'h55: c = 7'h0d;
      8'h58: c = 7'h3a;  8'h59: c = 7'h36;  8'h5A: c = 7'h1c;  8'h5B: c = 7'h1b;
      8'h5D: c = 7'h2b;  8'h66: c = 7'h0e;  8'h69: c = 7'h4f;  8'h6B: c = 7'h4b;
      8'h6C: c = 7'h47;  8'h70: c = 7'h52;  8'h71: c = 7'h53;  8'h72: c = 7'h50;
      8'h73: c = 7'h4c;  8'h74: c = 7'h4d;  8'h75: c = 7'h48;  8'h76: c = 7'h01;
      8'h77: c = 7'h45;  8'h78: c = 7'h57;  8'h79: c = 7'h4e;  8'h7A: c = 7'h51;
      8'h7B: c = 7'h4a;  8'h7C: c = 7'h37;  8'h7D: c = 7'h49;  8'h7E: c = 7'h46;
      8'h83: c = 7'h41;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Translation of a byte that follows the extended prefix.
  function automatic logic [CODE_W-1:0] extended_rom(input logic [7:0] b);
    logic [CODE_W-1:0] c;
    case (b)
      8'h11: c = 7'h65;  8'h14: c = 7'h66;  8'h4A: c = 7'h67;  8'h5A: c = 7'h68;
      8'h69: c = 7'h62;  8'h6B: c = 7'h6b;  8'h6C: c = 7'h61;  8'h70: c = 7'h5e;
      8'h71: c = 7'h5f;  8'h72: c = 7'h6a;  8'h74: c = 7'h6c;  8'h75: c = 7'h5a;
      8'h7A: c = 7'h64;  8'h7D: c = 7'h63;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/kevd_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps
`default_nettype none

// Request channel: keyboard bytes and pop commands.
interface kevd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

// Response channel: one beat per pop command.
interface kevd_out_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic       key_pressed;
  logic [6:0] key_code;

  modport source (output valid, event_valid, key_pressed, key_code, input ready);
  modport sink   (input valid, event_valid, key_pressed, key_code, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/kevd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module kevd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/kevd_front.sv @@
// Front end: prefix tracking and Set 2 translation into queue operations.
`timescale 1ns / 1ps
`default_nettype none

module kevd_front
  import kevd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  kevd_in_if.sink    req,
  output logic       op_valid,
  input  wire logic  op_ready,
  output op_t        op
);

  logic              break_pending;
  logic              extended_pending;
  logic              break_pending_next;
  logic              extended_pending_next;
  logic [CODE_W-1:0] code;
  logic              is_prefix_or_ignored;
  logic              req_fire;

  // A beat is taken whenever the operation queue has room.
  assign req.ready = op_ready;
  assign req_fire  = req.valid && req.ready;

  // Classify the byte and look up its key code.
  always_comb begin
    code                  = extended_pending ? extended_rom(req.data_byte)
                                             : normal_rom(req.data_byte);
    is_prefix_or_ignored  = req.data_byte inside {BYTE_BREAK, BYTE_EXTEND, BYTE_PAUSE,
                                                  BYTE_ACK, BYTE_SELFTEST};
    break_pending_next    = break_pending;
    extended_pending_next = extended_pending;
    if (req.command == CMD_BYTE) begin
      if (req.data_byte == BYTE_BREAK) begin
        break_pending_next = 1'b1;
      end else if (req.data_byte == BYTE_EXTEND) begin
        extended_pending_next = 1'b1;
      end else if (!is_prefix_or_ignored) begin
        break_pending_next    = 1'b0;
        extended_pending_next = 1'b0;
      end
    end
  end

  // Pops always go to the back; bytes only when they name a key.
  always_comb begin
    op.is_pop  = (req.command == CMD_POP);
    op.pressed = (req.command == CMD_POP) ? 1'b0 : !break_pending;
    op.code    = (req.command == CMD_POP) ? '0 : code;
    op_valid   = req.valid &&
                 ((req.command == CMD_POP) || (!is_prefix_or_ignored && (code != '0)));
  end

  // Prefix flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      break_pending    <= 1'b0;
      extended_pending <= 1'b0;
    end else if (req_fire) begin
      break_pending    <= break_pending_next;
      extended_pending <= extended_pending_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/kevd_op_queue.sv @@
// Two-entry operation queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module kevd_op_queue
  import kevd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire op_t  in_op,
  output logic      out_valid,
  input  wire logic out_ready,
  output op_t       out_op
);

  logic [1:0] count;
  logic [1:0] wr_pos;
  logic       in_fire;
  logic       out_fire;
  op_t        slot0;
  op_t        slot1;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_op    = slot0;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign wr_pos    = count - {1'b0, out_fire};

  // Occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, in_fire} - {1'b0, out_fire};
    end
  end

  // Shift on a read, then place a new entry behind the survivors.
  always_ff @(posedge clk) begin
    if (out_fire) begin
      slot0 <= slot1;
    end
    if (in_fire) begin
      if (wr_pos == 2'd0) begin
        slot0 <= in_op;
      end else begin
        slot1 <= in_op;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/kevd_back.sv @@
// Back end: key event ring in RAM, pop reads and the response buffer.
`timescale 1ns / 1ps
`default_nettype none

module kevd_back
  import kevd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic op_valid,
  output logic      op_ready,
  input  wire op_t  op,
  kevd_out_if.source rsp
);

  typedef struct packed {
    logic              event_valid;
    logic              key_pressed;
    logic [CODE_W-1:0] key_code;
  } result_t;

  logic [PTR_W-1:0]   write_pointer;
  logic [PTR_W-1:0]   read_pointer;
  logic [PTR_W-1:0]   write_pointer_next;
  logic [PTR_W-1:0]   read_pointer_next;
  logic               queue_empty;
  logic               queue_full;
  logic               op_fire;
  logic               do_push;
  logic               do_read;
  logic               pend_valid;
  logic               pend_hit;
  logic [EVENT_W-1:0] rd_data;
  logic [1:0]         out_count;
  logic [1:0]         out_pos;
  logic [2:0]         out_load;
  logic               out_fire;
  logic               can_issue;
  result_t            pend_result;
  result_t            slot0;
  result_t            slot1;

  // Ring pointers wrap at the queue depth.
  assign write_pointer_next = (write_pointer == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : write_pointer + 1'b1;
  assign read_pointer_next  = (read_pointer == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : read_pointer + 1'b1;
  assign queue_empty = (write_pointer == read_pointer);
  assign queue_full  = (write_pointer_next == read_pointer);

  // A pop needs a free place in the response buffer, counting the read in flight.
  assign out_fire  = rsp.valid && rsp.ready;
  assign out_load  = {1'b0, out_count} + {2'b0, pend_valid} - {2'b0, out_fire};
  assign can_issue = (out_load < 3'd2);
  assign op_ready  = !op.is_pop || can_issue;
  assign op_fire   = op_valid && op_ready;
  assign do_push   = op_fire && !op.is_pop && !queue_full;
  assign do_read   = op_fire && op.is_pop && !queue_empty;

  kevd_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_event_store (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (write_pointer),
    .wr_data ({op.pressed, op.code}),
    .rd_en   (do_read),
    .rd_addr (read_pointer),
    .rd_data (rd_data)
  );

  // Pointers and the pop in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      pend_valid    <= 1'b0;
      pend_hit      <= 1'b0;
    end else begin
      if (do_push) begin
        write_pointer <= write_pointer_next;
      end
      if (do_read) begin
        read_pointer <= read_pointer_next;
      end
      pend_valid <= op_fire && op.is_pop;
      pend_hit   <= do_read;
    end
  end

  // An empty-queue pop answers with all fields zero.
  always_comb begin
    pend_result = '0;
    if (pend_hit) begin
      pend_result.event_valid = 1'b1;
      pend_result.key_pressed = rd_data[EVENT_W-1];
      pend_result.key_code    = rd_data[CODE_W-1:0];
    end
  end

  // Two-entry response buffer.
  assign out_pos = out_count - {1'b0, out_fire};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= 2'd0;
    end else begin
      out_count <= out_count + {1'b0, pend_valid} - {1'b0, out_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      slot0 <= slot1;
    end
    if (pend_valid) begin
      if (out_pos == 2'd0) begin
        slot0 <= pend_result;
      end else begin
        slot1 <= pend_result;
      end
    end
  end

  assign rsp.valid       = (out_count != 2'd0);
  assign rsp.event_valid = slot0.event_valid;
  assign rsp.key_pressed = slot0.key_pressed;
  assign rsp.key_code    = slot0.key_code;

`ifndef SYNTH
  // The response buffer never holds more than two beats.
  a_out_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_count <= 2'd2)
    else $error("response buffer overflow");

  // A returning read always finds a free place.
  a_pend_has_room: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (out_pos < 2'd2))
    else $error("pop result arrived without room");

  // A pop of an empty ring gives a not-valid result in the next cycle.
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (op_fire && op.is_pop && queue_empty) |=> (pend_valid && !pend_hit))
    else $error("empty pop did not report not-valid");

  // A push to a full ring leaves the write pointer where it was.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (op_fire && !op.is_pop && queue_full) |=> $stable(write_pointer))
    else $error("push to a full ring moved the write pointer");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ps2_set2_key_event_decoder_unit.sv @@
// Top level of the PS/2 Set 2 key event decoder.
// A pop's response passes the op queue, the pop register and the response buffer.
// Throughput: one request beat per cycle while the operation queue has room.
// The back end runs one operation per cycle; a pop waits only on response buffer room.
// Reset (rst, synchronous) clears the prefixes, ring pointers and queue counts.
// The event store RAM is not cleared; only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module ps2_set2_key_event_decoder_unit
  import kevd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  kevd_in_if.sink    req,
  kevd_out_if.source rsp
);

  logic front_valid;
  logic front_ready;
  op_t  front_op;
  logic back_valid;
  logic back_ready;
  op_t  back_op;

  kevd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .op_valid (front_valid),
    .op_ready (front_ready),
    .op       (front_op)
  );

  kevd_op_queue u_op_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_op     (front_op),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_op    (back_op)
  );

  kevd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (back_valid),
    .op_ready (back_ready),
    .op       (back_op),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire
